@@ design/fpa_pkg.sv @@
`default_nettype none
package fpa_pkg;

    localparam int unsigned FIELD_W = 32;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_GT     = 4'd4;
    localparam logic [3:0] OP_LT     = 4'd5;
    localparam logic [3:0] OP_GE     = 4'd6;
    localparam logic [3:0] OP_LE     = 4'd7;
    localparam logic [3:0] OP_EQ     = 4'd8;
    localparam logic [3:0] OP_NE     = 4'd9;
    localparam logic [3:0] OP_MIN    = 4'd10;
    localparam logic [3:0] OP_MAX    = 4'd11;
    localparam logic [3:0] OP_INC    = 4'd12;
    localparam logic [3:0] OP_DEC    = 4'd13;
    localparam logic [3:0] OP_TO_INT = 4'd14;

    typedef struct packed {
        logic [3:0]                op;
        logic signed [FIELD_W-1:0] operand_a;
        logic signed [FIELD_W-1:0] operand_b;
    } t_alu_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      compare_true;
        logic                      divide_by_zero;
    } t_alu_out;

endpackage
`default_nettype wire

@@ design/fixed_point_alu_q24_8.sv @@
`default_nettype none
// Signed fixed-point ALU, DATA_WIDTH bits with FRAC_BITS fraction bits.
// Input channel: drive i_in and raise start; the transaction is taken at any
// rising edge where start is high and busy is low. busy never rises: the
// block takes one transaction every cycle.
// Output channel: o_valid strobes for exactly one cycle with o_result; the
// receiver must take it then, it cannot hold the block off.
// Pipeline: an input stage, stage 1, the divide stages 2..NS and an output
// register. The depth is set by the restoring divider, one quotient bit per
// pipeline stage; every opcode travels the same stages so results leave in
// order.
// Throughput: one transaction per cycle for every opcode.
// The multiplier is one DATA_WIDTH x DATA_WIDTH product registered before
// its fraction shift.
// Reset clears all valid bits; transactions in flight are dropped and no
// strobe follows until new transactions arrive.
module fixed_point_alu_q24_8_core #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  fpa_pkg::t_alu_in     i_in,
    output logic                 o_valid,
    output fpa_pkg::t_alu_out    o_result
);
    import fpa_pkg::*;

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;
    localparam int unsigned NS = QW + 1;

    // input stage
    logic                 r_v0;
    logic [3:0]           r_op0;
    logic signed [DW-1:0] r_a0;
    logic signed [DW-1:0] r_b0;

    // pipeline stages 1..NS
    logic                 r_v   [1:NS];
    logic [3:0]           r_op  [1:NS];
    logic [DW-1:0]        r_res [1:NS];
    logic                 r_cmp [1:NS];
    logic                 r_dz  [1:NS];
    logic                 r_neg [1:NS];
    logic [DW-1:0]        r_d   [1:NS];
    logic [DW-1:0]        r_rem [1:NS];
    logic [QW-1:0]        r_dq  [1:NS];
    logic signed [2*DW-1:0] r_prod;

    logic                 r_ov;
    t_alu_out             r_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_op0 <= i_in.op;
        r_a0  <= i_in.operand_a[DW-1:0];
        r_b0  <= i_in.operand_b[DW-1:0];
    end

    // stage 1: simple operations, multiplier, divider set-up
    logic [DW-1:0]        n_res1;
    logic                 n_cmp1;
    logic                 n_dz1;
    logic [DW-1:0]        n_amag;
    logic [DW-1:0]        n_bmag;
    logic signed [DW-1:0] n_fl;
    logic                 n_frac_nz;

    always_comb begin
        n_res1    = '0;
        n_cmp1    = 1'b0;
        n_dz1     = 1'b0;
        n_amag    = r_a0[DW-1] ? DW'(-r_a0) : DW'(r_a0);
        n_bmag    = r_b0[DW-1] ? DW'(-r_b0) : DW'(r_b0);
        n_fl      = r_a0 >>> FRAC_BITS;
        n_frac_nz = |r_a0[FRAC_BITS-1:0];
        unique case (r_op0)
            OP_ADD:    n_res1 = DW'(r_a0 + r_b0);
            OP_SUB:    n_res1 = DW'(r_a0 - r_b0);
            OP_MUL:    n_res1 = '0;
            OP_DIV:    n_dz1  = (r_b0 == '0);
            OP_GT:     n_cmp1 = (r_a0 >  r_b0);
            OP_LT:     n_cmp1 = (r_a0 <  r_b0);
            OP_GE:     n_cmp1 = (r_a0 >= r_b0);
            OP_LE:     n_cmp1 = (r_a0 <= r_b0);
            OP_EQ:     n_cmp1 = (r_a0 == r_b0);
            OP_NE:     n_cmp1 = (r_a0 != r_b0);
            OP_MIN:    n_res1 = (r_a0 < r_b0) ? r_a0 : r_b0;
            OP_MAX:    n_res1 = (r_a0 > r_b0) ? r_a0 : r_b0;
            OP_INC:    n_res1 = DW'(r_a0 + 1);
            OP_DEC:    n_res1 = DW'(r_a0 - 1);
            // round toward zero: lift negative values with a dropped fraction
            OP_TO_INT: n_res1 = DW'(n_fl + DW'(r_a0[DW-1] & n_frac_nz));
            default:   n_res1 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[1] <= 1'b0;
        end else begin
            r_v[1] <= r_v0;
        end
        r_op[1]  <= r_op0;
        r_res[1] <= n_res1;
        r_cmp[1] <= n_cmp1;
        r_dz[1]  <= n_dz1;
        r_neg[1] <= r_a0[DW-1] ^ r_b0[DW-1];
        r_d[1]   <= n_bmag;
        r_rem[1] <= '0;
        r_dq[1]  <= {n_amag, {FRAC_BITS{1'b0}}};
        r_prod   <= r_a0 * r_b0;
    end

    // stages 2..NS: one restoring divide step each
    for (genvar k = 2; k <= NS; k++) begin : g_div
        logic [DW-1:0] n_sh;
        logic [DW:0]   n_diff;
        logic [DW-1:0] n_res;

        assign n_sh   = {r_rem[k-1][DW-2:0], r_dq[k-1][QW-1]};
        assign n_diff = {1'b0, n_sh} - {1'b0, r_d[k-1]};

        if (k == 2) begin : g_mul
            // take the product's shifted window once it is registered
            assign n_res = (r_op[k-1] == OP_MUL) ? r_prod[FRAC_BITS +: DW]
                                                 : r_res[k-1];
        end else begin : g_pass
            assign n_res = r_res[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_op[k]  <= r_op[k-1];
            r_res[k] <= n_res;
            r_cmp[k] <= r_cmp[k-1];
            r_dz[k]  <= r_dz[k-1];
            r_neg[k] <= r_neg[k-1];
            r_d[k]   <= r_d[k-1];
            r_rem[k] <= n_diff[DW] ? n_sh : n_diff[DW-1:0];
            r_dq[k]  <= {r_dq[k-1][QW-2:0], ~n_diff[DW]};
        end
    end

    // output stage: sign the quotient and register the result
    logic signed [DW-1:0] n_val;

    always_comb begin
        n_val = r_res[NS];
        if (r_op[NS] == OP_DIV && !r_dz[NS]) begin
            n_val = r_neg[NS] ? DW'(-r_dq[NS][DW-1:0]) : r_dq[NS][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NS];
        end
        r_out.value          <= FIELD_W'(n_val);
        r_out.compare_true   <= r_cmp[NS];
        r_out.divide_by_zero <= r_dz[NS];
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import fpa_pkg::*;

    localparam int LATENCY   = 42;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1300;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_alu_in  i_in = '0;
    logic     o_valid;
    t_alu_out o_result;

    fixed_point_alu_q24_8_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_result(o_result)
    );

    always #10 i_clk = ~i_clk;

    t_alu_out alu_expected_q[$];
    int       err_cnt = 0;
    int       wdog = 0;
    int       idle_pct = 0;

    function automatic t_alu_out alu_predict(t_alu_in t);
        t_alu_out          r;
        logic signed [63:0] a, b, p;
        a = 64'(t.operand_a);
        b = 64'(t.operand_b);
        r = '0;
        case (t.op)
            OP_ADD:    r.value = 32'(a + b);
            OP_SUB:    r.value = 32'(a - b);
            OP_MUL: begin
                p = a * b;
                r.value = 32'(p >>> 8);
            end
            OP_DIV: begin
                if (b == 0) r.divide_by_zero = 1'b1;
                else begin
                    p = (a <<< 8) / b;
                    r.value = 32'(p);
                end
            end
            OP_GT:     r.compare_true = a > b;
            OP_LT:     r.compare_true = a < b;
            OP_GE:     r.compare_true = a >= b;
            OP_LE:     r.compare_true = a <= b;
            OP_EQ:     r.compare_true = a == b;
            OP_NE:     r.compare_true = a != b;
            OP_MIN:    r.value = 32'((a < b) ? a : b);
            OP_MAX:    r.value = 32'((a > b) ? a : b);
            OP_INC:    r.value = 32'(a + 1);
            OP_DEC:    r.value = 32'(a - 1);
            OP_TO_INT: begin
                p = a / 256;
                r.value = 32'(p);
            end
            default:   r = '0;
        endcase
        return r;
    endfunction

    // check results as they strobe out
    always @(posedge i_clk) begin
        t_alu_out e;
        if (i_rst_n && o_valid) begin
            if (alu_expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                err_cnt++;
            end else begin
                e = alu_expected_q.pop_front();
                if (o_result.value !== e.value) begin
                    $display("%0t: value exp %h got %h", $time, e.value, o_result.value);
                    err_cnt++;
                end
                if (o_result.compare_true !== e.compare_true) begin
                    $display("%0t: compare_true exp %b got %b", $time,
                             e.compare_true, o_result.compare_true);
                    err_cnt++;
                end
                if (o_result.divide_by_zero !== e.divide_by_zero) begin
                    $display("%0t: divide_by_zero exp %b got %b", $time,
                             e.divide_by_zero, o_result.divide_by_zero);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    typedef struct {
        t_alu_in  stim;
        bit       has_exp;
        t_alu_out exp_res;
    } t_dir_row;

    t_dir_row dir_tbl[$];

    function automatic t_alu_in mk(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        t_alu_in t;
        t.op = op;
        t.operand_a = a;
        t.operand_b = b;
        return t;
    endfunction

    function automatic t_alu_out mko(logic [31:0] v, int c, int d);
        t_alu_out r;
        r.value = v;
        r.compare_true = c[0];
        r.divide_by_zero = d[0];
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
            3: return $signed($urandom_range(0, 4095)) - 2048;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_alu_in t, bit has_exp, t_alu_out ex);
        t_alu_out p;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = alu_predict(t);
        if (has_exp && p !== ex) begin
            $display("%0t: table row exp %h predictor %h", $time, ex, p);
            err_cnt++;
        end
        alu_expected_q.push_back(has_exp ? ex : p);
    endtask

    initial begin
        t_alu_in t;
        dir_tbl.push_back('{mk(OP_ADD, 32'h7FFF_FFFF, 32'd1), 1'b1,
                            mko(32'h8000_0000, 0, 0)});
        dir_tbl.push_back('{mk(OP_SUB, 32'h8000_0000, 32'd1), 1'b1,
                            mko(32'h7FFF_FFFF, 0, 0)});
        dir_tbl.push_back('{mk(OP_MUL, 32'h100, 32'h100), 1'b1,
                            mko(32'h100, 0, 0)});
        dir_tbl.push_back('{mk(OP_MUL, 32'hFFFF_FFFF, 32'd1), 1'b1,
                            mko(32'hFFFF_FFFF, 0, 0)});
        dir_tbl.push_back('{mk(OP_MUL, 32'h8000_0000, 32'h8000_0000), 1'b0, '0});
        dir_tbl.push_back('{mk(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0});
        dir_tbl.push_back('{mk(OP_DIV, 32'h100, 32'd0), 1'b1,
                            mko(32'd0, 0, 1)});
        dir_tbl.push_back('{mk(OP_DIV, 32'h8000_0000, 32'd0), 1'b1,
                            mko(32'd0, 0, 1)});
        dir_tbl.push_back('{mk(OP_DIV, 32'h200, 32'h100), 1'b1,
                            mko(32'h200, 0, 0)});
        dir_tbl.push_back('{mk(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0});
        dir_tbl.push_back('{mk(OP_DIV, 32'hFFFF_FF00, 32'd3), 1'b0, '0});
        dir_tbl.push_back('{mk(OP_GT, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                            mko(0, 1, 0)});
        dir_tbl.push_back('{mk(OP_LT, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                            mko(0, 0, 0)});
        dir_tbl.push_back('{mk(OP_GE, 32'd5, 32'd5), 1'b1,
                            mko(0, 1, 0)});
        dir_tbl.push_back('{mk(OP_LE, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
                            mko(0, 1, 0)});
        dir_tbl.push_back('{mk(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                            mko(0, 1, 0)});
        dir_tbl.push_back('{mk(OP_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                            mko(0, 0, 0)});
        dir_tbl.push_back('{mk(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
                            mko(32'h8000_0000, 0, 0)});
        dir_tbl.push_back('{mk(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
                            mko(32'h7FFF_FFFF, 0, 0)});
        dir_tbl.push_back('{mk(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                            mko(32'h8000_0000, 0, 0)});
        dir_tbl.push_back('{mk(OP_DEC, 32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
                            mko(32'h7FFF_FFFF, 0, 0)});
        dir_tbl.push_back('{mk(OP_TO_INT, 32'hFFFF_FF80, 32'd0), 1'b1,
                            mko(32'd0, 0, 0)});
        dir_tbl.push_back('{mk(OP_TO_INT, 32'h8000_0000, 32'd7), 1'b1,
                            mko(32'hFF80_0000, 0, 0)});
        dir_tbl.push_back('{mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                            mko(32'd0, 0, 0)});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) send(dir_tbl[i].stim, dir_tbl[i].has_exp, dir_tbl[i].exp_res);

        for (int n = 0; n < N_RANDOM; n++) begin
            // sender idles 22%, then 74%, then not at all
            if (n < N_RANDOM / 3) idle_pct = 22;
            else if (n < 2 * N_RANDOM / 3) idle_pct = 74;
            else idle_pct = 0;
            t.op = 4'($urandom_range(0, 15));
            t.operand_a = rand_operand();
            t.operand_b = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_operand();
            if ($urandom_range(0, 7) == 0) t.operand_b = t.operand_a;
            send(t, 1'b0, '0);
        end
        start <= 1'b0;

        while (alu_expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
